// File: hw/rtl/gait_phase_torque_generator_core_defines.svh
// Assertion macros shared by the gait phase torque generator RTL.
// Included by the top level; depends on nothing else.
`ifndef GAIT_PHASE_TORQUE_GENERATOR_CORE_DEFINES_SVH
`define GAIT_PHASE_TORQUE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GPTG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GPTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gptg_pkg.sv
// Types, codes and the torque shape table of the gait phase torque generator.
// Has no dependencies; the front end, queue, back end and top level import it.
`timescale 1ns / 1ps
`default_nettype none

package gptg_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_AMPLITUDE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_OFFSET_SELECT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_MODE           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TORQUE_LIMIT        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY_THRESHOLD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STRIDE_MS       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STRIDE_MS       = 3'd6;

  localparam logic [1:0] OFFSET_MINUS = 2'd0;
  localparam logic [1:0] OFFSET_NONE  = 2'd1;
  localparam logic [1:0] OFFSET_PLUS  = 2'd2;

  localparam logic [1:0] SIDE_SYMMETRIC  = 2'd0;
  localparam logic [1:0] SIDE_LEFT_HALF  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT_HALF = 2'd2;
  localparam logic [1:0] SIDE_BOTH_ZERO  = 2'd3;

  localparam logic [11:0] RESET_AMPLITUDE  = 12'd1024;
  localparam logic [11:0] RESET_LIMIT      = 12'd3072;
  localparam logic [12:0] RESET_THRESHOLD  = 13'd100;
  localparam logic [15:0] RESET_MIN_STRIDE = 16'd400;
  localparam logic [15:0] RESET_MAX_STRIDE = 16'd3000;
  localparam logic [15:0] RESET_STRIDE     = 16'd1000;

  localparam logic [6:0] PCT_MAX    = 7'd100;
  localparam int         REM_W      = 23;
  localparam int         DSH_W      = 22;
  localparam int         PROD_W     = 27;
  localparam logic [2:0] DIV_STEPS  = 3'd6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    PCT_ZERO = 2'd0,
    PCT_FULL = 2'd1,
    PCT_DIV  = 2'd2
  } pct_mode_t;

  typedef struct packed {
    logic [11:0] torque_amplitude;
    logic [1:0]  phase_offset_select;
    logic [1:0]  side_mode;
    logic [11:0] torque_limit;
    logic [12:0] velocity_threshold;
    logic [15:0] min_stride_ms;
    logic [15:0] max_stride_ms;
  } cfg_t;

  typedef struct packed {
    logic      zero_out;
    pct_mode_t pct_mode;
    logic [15:0] since;
    logic [15:0] stride;
  } job_t;

  typedef struct packed {
    logic idle;
    logic load;
  } back_status_t;

  // Q1.14 torque shape over the wrapped gait percent.
  localparam int SHAPE_Q14 [0:99] = '{
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 1713, 3406, 5063, 6664, 8192, 9630, 10963, 12176, 13255,
    14189, 14968, 15582, 16026, 16294, 16384, 16294, 16026, 15582, 14968,
    14189, 13255, 12176, 10963, 9630, 8192, 6664, 5063, 3406, 1713,
    0, -2563, -5063, -7438, -9630, -11585, -13255, -14598, -15582, -16182,
    -16384, -16182, -15582, -14598, -13255, -11585, -9630, -7438, -5063, -2563,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

endpackage

`default_nettype wire

// File: hw/rtl/gptg_if.sv
// Valid/ready channel interfaces for tick items and torque result items.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface gptg_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       time_ms;
  logic signed [13:0] forward_velocity;
  logic              left_stance;
  logic              assist_enabled;

  modport source(output valid, time_ms, forward_velocity, left_stance, assist_enabled,
                 input ready);
  modport sink(input valid, time_ms, forward_velocity, left_stance, assist_enabled,
               output ready);
endinterface

interface gptg_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] torque_right;
  logic signed [12:0] torque_left;
  logic [6:0]         phase_percent;

  modport source(output valid, torque_right, torque_left, phase_percent, input ready);
  modport sink(input valid, torque_right, torque_left, phase_percent, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/gptg_front.sv
// Front end: accepts tick items, tracks heel strikes and the stride period,
// and classifies each item into a job. Depends on gptg_pkg and gptg_if.
`timescale 1ns / 1ps
`default_nettype none

module gptg_front import gptg_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gptg_in_if.sink    din,
  input  wire cfg_t  cfg,
  output job_t       job,
  output logic       job_valid,
  input  wire logic  job_ready
);

  logic                 previous_left_contact;
  logic [TIME_BITS-1:0] last_heel_strike_time;
  logic [15:0]          stride_period;
  logic                 have_heel_strike;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] since;
  logic signed [14:0]   vel_ext;
  logic signed [14:0]   thr_ext;
  logic                 vel_low;
  logic                 heel;
  logic                 in_range;
  logic [15:0]          stride_next;
  logic                 have_next;
  logic                 accept;

  assign now      = din.time_ms[TIME_BITS-1:0];
  assign diff     = now - last_heel_strike_time;
  assign vel_ext  = {din.forward_velocity[13], din.forward_velocity};
  assign thr_ext  = {2'b00, cfg.velocity_threshold};
  assign vel_low  = vel_ext < thr_ext;
  assign heel     = din.left_stance && !previous_left_contact;
  assign in_range = have_heel_strike && (diff >= TIME_BITS'(cfg.min_stride_ms))
                    && (diff <= TIME_BITS'(cfg.max_stride_ms));
  assign stride_next = (heel && in_range) ? diff[15:0] : stride_period;
  assign have_next   = have_heel_strike || heel;
  assign since       = heel ? '0 : diff;

  assign accept    = din.valid && din.ready;
  assign din.ready = job_ready;
  assign job_valid = din.valid;

  always_comb begin
    job.zero_out = !din.assist_enabled || vel_low;
    job.since    = since[15:0];
    job.stride   = stride_next;
    if (job.zero_out || !have_next || (stride_next == 16'd0)) begin
      job.pct_mode = PCT_ZERO;
    end else if (since >= TIME_BITS'(stride_next)) begin
      job.pct_mode = PCT_FULL;
    end else begin
      job.pct_mode = PCT_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_left_contact <= 1'b0;
      last_heel_strike_time <= '0;
      stride_period         <= RESET_STRIDE;
      have_heel_strike      <= 1'b0;
    end else if (accept && din.assist_enabled) begin
      if (vel_low) begin
        have_heel_strike <= 1'b0;
      end else begin
        previous_left_contact <= din.left_stance;
        have_heel_strike      <= have_next;
        stride_period         <= stride_next;
        if (heel) begin
          last_heel_strike_time <= now;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gptg_queue.sv
// Short job queue between the front end and the back end.
// Depends on gptg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gptg_queue import gptg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire job_t push_job,
  output logic      push_ready,
  output logic      pop_valid,
  output job_t      pop_job,
  input  wire logic pop
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gptg_back.sv
// Back end: serial percent divider, phase offset, shape lookup, amplitude
// multiply, side sharing, clamp and the result register. Depends on gptg_pkg and gptg_if.
`timescale 1ns / 1ps
`default_nettype none

module gptg_back import gptg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  job_valid,
  input  wire job_t  job,
  output logic       job_pop,
  gptg_out_if.source dout,
  output back_status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_IDX  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t            state;
  logic              zero_out;
  logic [6:0]        pct;
  logic [REM_W-1:0]  rem;
  logic [DSH_W-1:0]  dsh;
  logic [6:0]        quo;
  logic [2:0]        cnt;
  logic [6:0]        idx;
  logic              neg;
  logic [PROD_W-1:0] prod;

  logic              fits;
  logic [6:0]        quo_next;
  logic signed [7:0] p_sum;
  logic signed [7:0] p_wrap;
  logic signed [15:0] entry;
  logic [14:0]       mag;
  logic [PROD_W:0]   rounded;
  logic [13:0]       m;
  logic signed [13:0] tau;
  logic signed [13:0] tr;
  logic signed [13:0] tl;
  logic              load;

  function automatic logic signed [12:0] clamp_torque(input logic signed [13:0] t,
                                                       input logic [11:0] lim);
    logic signed [13:0] l;
    l = $signed({2'b00, lim});
    if (t > l) begin
      return 13'(l);
    end else if (t < -l) begin
      return 13'(-l);
    end
    return 13'(t);
  endfunction

  assign fits     = rem >= REM_W'(dsh);
  assign quo_next = {quo[5:0], fits};

  always_comb begin
    case (cfg.phase_offset_select)
      OFFSET_MINUS: p_sum = $signed({1'b0, pct}) - 8'sd10;
      OFFSET_PLUS:  p_sum = $signed({1'b0, pct}) + 8'sd10;
      default:      p_sum = $signed({1'b0, pct});
    endcase
    if (p_sum < 8'sd0) begin
      p_wrap = p_sum + 8'sd100;
    end else if (p_sum >= 8'sd100) begin
      p_wrap = p_sum - 8'sd100;
    end else begin
      p_wrap = p_sum;
    end
  end

  assign entry = 16'(SHAPE_Q14[idx]);
  assign mag   = entry[15] ? 15'(-entry) : entry[14:0];

  assign rounded = {1'b0, prod} + (PROD_W + 1)'(8192);
  assign m       = rounded[PROD_W:14];
  assign tau     = neg ? -$signed(m) : $signed(m);

  always_comb begin
    case (cfg.side_mode)
      SIDE_SYMMETRIC: begin
        tr = tau;
        tl = tau;
      end
      SIDE_LEFT_HALF: begin
        tr = tau;
        tl = tau >>> 1;
      end
      SIDE_RIGHT_HALF: begin
        tr = tau >>> 1;
        tl = tau;
      end
      default: begin
        tr = '0;
        tl = '0;
      end
    endcase
  end

  assign load        = (state == ST_FIN) && (!dout.valid || dout.ready);
  assign job_pop     = (state == ST_IDLE) && job_valid;
  assign status.idle = state == ST_IDLE;
  assign status.load = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= (job.pct_mode == PCT_DIV) ? ST_DIV : ST_IDX;
          end
        end
        ST_DIV: begin
          if (cnt == 3'd0) begin
            state <= ST_IDX;
          end
        end
        ST_IDX:  state <= ST_MUL;
        ST_MUL:  state <= ST_FIN;
        ST_FIN: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        zero_out <= job.zero_out;
        rem      <= REM_W'(job.since) * REM_W'(100);
        dsh      <= {job.stride, 6'b0};
        quo      <= '0;
        cnt      <= DIV_STEPS;
        case (job.pct_mode)
          PCT_FULL: pct <= PCT_MAX;
          default:  pct <= '0;
        endcase
      end
      ST_DIV: begin
        if (fits) begin
          rem <= rem - REM_W'(dsh);
        end
        dsh <= dsh >> 1;
        quo <= quo_next;
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          pct <= quo_next;
        end
      end
      ST_IDX: idx <= 7'(p_wrap);
      ST_MUL: begin
        neg  <= entry[15];
        prod <= PROD_W'(mag) * PROD_W'(cfg.torque_amplitude);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (load) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (zero_out) begin
        dout.torque_right  <= '0;
        dout.torque_left   <= '0;
        dout.phase_percent <= '0;
      end else begin
        dout.torque_right  <= clamp_torque(tr, cfg.torque_limit);
        dout.torque_left   <= clamp_torque(tl, cfg.torque_limit);
        dout.phase_percent <= pct;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gait_phase_torque_generator_core.sv
// Top level of the gait phase torque generator: configuration registers,
// front end, job queue and back end. Depends on gptg_pkg, gptg_if and the defines header.
//
//   channel   direction  handshake          payload
//   din       in         valid/ready        time_ms, forward_velocity, left_stance,
//                                           assist_enabled
//   dout      out        valid/ready        torque_right, torque_left, phase_percent
//   cfg       in         cfg_we only        cfg_index, cfg_wdata
//
// The front end takes one item per cycle while the two-entry queue has room.
// The back end runs an item that needs the percent divide through seven
// one-bit divider steps, then index, multiply and final steps; other items skip the divider.
// Reset is synchronous; the stride estimator comes up with a 1000 ms period.
// A stalled dout holds its result register and the back end waits in its last step.
`timescale 1ns / 1ps
`default_nettype none
`include "gait_phase_torque_generator_core_defines.svh"

module gait_phase_torque_generator_core import gptg_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  gptg_in_if.sink                     din,
  gptg_out_if.source                  dout,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t         cfg;
  job_t         f_job;
  logic         f_valid;
  logic         q_ready;
  job_t         q_job;
  logic         q_valid;
  logic         q_pop;
  back_status_t back_st;
  logic         pct_ok;
  logic         out_done;
  logic         back_waiting;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.torque_amplitude    <= RESET_AMPLITUDE;
      cfg.phase_offset_select <= OFFSET_NONE;
      cfg.side_mode           <= SIDE_SYMMETRIC;
      cfg.torque_limit        <= RESET_LIMIT;
      cfg.velocity_threshold  <= RESET_THRESHOLD;
      cfg.min_stride_ms       <= RESET_MIN_STRIDE;
      cfg.max_stride_ms       <= RESET_MAX_STRIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TORQUE_AMPLITUDE:    cfg.torque_amplitude    <= cfg_wdata[11:0];
        CFG_PHASE_OFFSET_SELECT: cfg.phase_offset_select <= cfg_wdata[1:0];
        CFG_SIDE_MODE:           cfg.side_mode           <= cfg_wdata[1:0];
        CFG_TORQUE_LIMIT:        cfg.torque_limit        <= cfg_wdata[11:0];
        CFG_VELOCITY_THRESHOLD:  cfg.velocity_threshold  <= cfg_wdata[12:0];
        CFG_MIN_STRIDE_MS:       cfg.min_stride_ms       <= cfg_wdata;
        CFG_MAX_STRIDE_MS:       cfg.max_stride_ms       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gptg_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .cfg      (cfg),
    .job      (f_job),
    .job_valid(f_valid),
    .job_ready(q_ready)
  );

  gptg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_job  (f_job),
    .push_ready(q_ready),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  gptg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .job_valid(q_valid),
    .job      (q_job),
    .job_pop  (q_pop),
    .dout     (dout),
    .status   (back_st)
  );

  assign pct_ok       = dout.phase_percent <= PCT_MAX;
  assign out_done     = dout.valid && dout.ready && !back_st.load;
  assign back_waiting = back_st.idle && q_valid;

  `GPTG_ASSERT_IMPLIES(a_pct_range, clk, rst, dout.valid, pct_ok, "phase percent above 100")
  `GPTG_ASSERT_NEXT(a_out_drain, clk, rst, out_done, !dout.valid, "result register not drained")
  `GPTG_ASSERT_NEXT(a_back_takes, clk, rst, back_waiting, !back_st.idle, "queued item left waiting")

endmodule

`default_nettype wire
